// ----- rtl/sgfp_pkg.sv -----
`default_nettype none
package sgfp_pkg;

  // frame length: start byte included, checksum byte not
  localparam int FRAME_BYTES = 7;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

  localparam logic [7:0] START_BYTE = 8'd2;
  localparam logic [CNT_W-1:0] TACHO_POS = CNT_W'(2);
  localparam logic [CNT_W-1:0] SPEED_POS = CNT_W'(3);
  localparam logic signed [15:0] TACHO_SCALE = 16'sd100;
  localparam logic signed [15:0] TACHO_RESET = -16'sd1;
  localparam logic signed [8:0]  SPEED_RESET = -9'sd1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one completed frame, handed from front to back
  typedef struct packed {
    logic       ok;
    logic [7:0] tacho_byte;
    logic [7:0] speed_byte;
  } frm_t;

endpackage
`default_nettype wire

// ----- rtl/sgfp_front.sv -----
`default_nettype none
module sgfp_front
  import sgfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] rx_byte,
  output logic            push,
  output frm_t            push_frm
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       tb_r, tb_nxt;
  logic [7:0]       sb_r, sb_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    tb_nxt  = tb_r;
    sb_nxt  = sb_r;
    push    = 1'b0;
    push_frm.ok         = (sum_r == rx_byte);
    push_frm.tacho_byte = tb_r;
    push_frm.speed_byte = sb_r;
    if (acc) begin
      priority if (cnt_r == '0 && rx_byte != START_BYTE) begin
        // idle, not a start byte: dropped
      end else if (cnt_r < CNT_W'(FRAME_BYTES)) begin
        if (cnt_r == TACHO_POS) tb_nxt = rx_byte;
        if (cnt_r == SPEED_POS) sb_nxt = rx_byte;
        sum_nxt = sum_r + rx_byte;
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        // checksum word closes the frame
        push    = 1'b1;
        cnt_nxt = '0;
        sum_nxt = '0;
        tb_nxt  = '0;
        sb_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      tb_r  <= '0;
      sb_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      tb_r  <= tb_nxt;
      sb_r  <= sb_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sgfp_queue.sv -----
`default_nettype none
module sgfp_queue
  import sgfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire frm_t push_frm,
  output logic      full,
  output logic      pop_valid,
  output frm_t      pop_frm,
  input  wire logic pop
);

  frm_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_frm   = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_frm;
  end

endmodule
`default_nettype wire

// ----- rtl/sgfp_back.sv -----
`default_nettype none
module sgfp_back
  import sgfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         frm_valid,
  input  wire frm_t         frm,
  output logic              frm_pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_checksum_ok,
  output logic signed [15:0] out_tacho_value,
  output logic              out_tacho_changed,
  output logic signed [8:0] out_speed_value,
  output logic              out_speed_changed
);

  logic signed [15:0] last_tacho_r, last_tacho_nxt;
  logic signed [8:0]  last_speed_r, last_speed_nxt;
  logic               out_valid_r;
  logic               ok_r, tch_r, sch_r;
  logic signed [15:0] tacho_m1, new_tacho;
  logic signed [8:0]  new_speed;
  logic               tch, sch;

  assign frm_pop = frm_valid && (!out_valid_r || out_ready);

  always_comb begin
    tacho_m1  = signed'({8'd0, frm.tacho_byte}) - 16'sd1;
    new_tacho = 16'(tacho_m1 * TACHO_SCALE);
    new_speed = signed'({1'b0, frm.speed_byte}) - 9'sd1;
    tch = frm.ok && (new_tacho != last_tacho_r);
    sch = frm.ok && (new_speed != last_speed_r);
    last_tacho_nxt = tch ? new_tacho : last_tacho_r;
    last_speed_nxt = sch ? new_speed : last_speed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      last_tacho_r <= TACHO_RESET;
      last_speed_r <= SPEED_RESET;
    end else begin
      if (frm_pop) begin
        out_valid_r  <= 1'b1;
        last_tacho_r <= last_tacho_nxt;
        last_speed_r <= last_speed_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frm_pop) begin
      ok_r  <= frm.ok;
      tch_r <= tch;
      sch_r <= sch;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_checksum_ok   = ok_r;
  assign out_tacho_value   = last_tacho_r;
  assign out_tacho_changed = tch_r;
  assign out_speed_value   = last_speed_r;
  assign out_speed_changed = sch_r;

endmodule
`default_nettype wire

// ----- rtl/serial_gauge_frame_parser.sv -----
// channel  direction  word                         handshake
// in       input      rx_byte                      in_valid / in_ready
// out      output     checksum_ok, tacho, speed    out_valid / out_ready
//
// one byte is taken per cycle; the running sum finishes each byte in its cycle
// a completed frame goes through a two-entry queue to the back end, which
// updates the gauge values and loads them into the output registers
// in_ready drops only while the queue is full; out_ready low stalls the back end
// synchronous active-low reset: idle frame, values at -1, no result pending
`default_nettype none
module serial_gauge_frame_parser
  import sgfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_rx_byte,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_checksum_ok,
  output logic signed [15:0] out_tacho_value,
  output logic              out_tacho_changed,
  output logic signed [8:0] out_speed_value,
  output logic              out_speed_changed
);

  logic q_full, push, pop_valid, pop;
  frm_t push_frm, pop_frm;

  assign in_ready = !q_full;

  sgfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_valid && in_ready),
    .rx_byte  (in_rx_byte),
    .push     (push),
    .push_frm (push_frm)
  );

  sgfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_frm  (push_frm),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop_frm   (pop_frm),
    .pop       (pop)
  );

  sgfp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .frm_valid         (pop_valid),
    .frm               (pop_frm),
    .frm_pop           (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_checksum_ok   (out_checksum_ok),
    .out_tacho_value   (out_tacho_value),
    .out_tacho_changed (out_tacho_changed),
    .out_speed_value   (out_speed_value),
    .out_speed_changed (out_speed_changed)
  );

endmodule
`default_nettype wire
